FILE: rtl/mexican_hat_wavelet_eval_core_defines.svh
`ifndef MEXICAN_HAT_WAVELET_EVAL_CORE_DEFINES_SVH
`define MEXICAN_HAT_WAVELET_EVAL_CORE_DEFINES_SVH

// same-cycle implication
`define MHW_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MHW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mhw_pkg.sv
package mhw_pkg;

  localparam int X_FRAC_BITS_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 24;
  localparam int MAX_LEVEL_DEF     = 10;

  localparam int PQ = 24;
  localparam int EQ = 30;

  localparam int FUNC_W = 2;
  localparam int X_W    = 18;
  localparam int LEV_W  = 4;
  localparam int K_W    = 11;
  localparam int VAL_W  = 48;

  localparam logic [FUNC_W-1:0] FUNC_VALUE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_D1    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_D2    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  // |t| < 8 in up to Q.24
  localparam int MT_W  = 27;
  localparam int T24_W = 28;
  localparam int S24_W = 30;
  localparam int Y_W   = 29;
  localparam int EP_W  = 31;
  localparam int E_W   = 25;

  localparam int TAYLOR_TERMS = 10;
  localparam int SQUARINGS    = 6;
  localparam int EXP_LAT      = 3 * TAYLOR_TERMS + SQUARINGS;

  localparam logic [23:0] C_Q24 = 24'd12895754;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic                     zero;
    logic [FUNC_W-1:0]        func;
    logic [LEV_W-1:0]         lev;
    logic [MT_W-1:0]          mt;
    logic signed [T24_W-1:0]  t24;
  } item_t;

endpackage

FILE: rtl/mhw_front.sv
module mhw_front #(
  parameter int X_FRAC_BITS = mhw_pkg::X_FRAC_BITS_DEF,
  parameter int MAX_LEVEL   = mhw_pkg::MAX_LEVEL_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [mhw_pkg::FUNC_W-1:0]       func,
  input  logic signed [mhw_pkg::X_W-1:0]   x_pos,
  input  logic [mhw_pkg::LEV_W-1:0]        level,
  input  logic signed [mhw_pkg::K_W-1:0]   shift,
  output logic                             push,
  output mhw_pkg::item_t                   item
);
  import mhw_pkg::*;

  localparam int XL_W = X_W + MAX_LEVEL;
  localparam int KS_W = K_W + X_FRAC_BITS;
  localparam int U_W  = (XL_W > KS_W ? XL_W : KS_W) + 1;
  localparam int T_W  = U_W + 2;

  logic                     vld;
  logic [FUNC_W-1:0]        func_r;
  logic signed [X_W-1:0]    x_r;
  logic [LEV_W-1:0]         lev_r;
  logic signed [K_W-1:0]    k_r;

  logic [LEV_W-1:0]         lev_c;
  logic signed [T_W-1:0]    u;
  logic signed [T_W-1:0]    t;
  logic [T_W-1:0]           mt;
  logic                     far;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= func;
      x_r    <= x_pos;
      lev_r  <= level;
      k_r    <= shift;
    end
  end

  always_comb begin
    lev_c = (lev_r > LEV_W'(MAX_LEVEL)) ? LEV_W'(MAX_LEVEL) : lev_r;
    u     = (T_W'(x_r) <<< lev_c) - (T_W'(k_r) <<< X_FRAC_BITS);
    t     = (u <<< 1) - (T_W'(1) <<< X_FRAC_BITS);
    mt    = t[T_W-1] ? T_W'(-t) : T_W'(t);
    far   = mt >= (T_W'(8) << X_FRAC_BITS);
  end

  always_comb begin
    item.zero = far || (func_r == FUNC_NONE);
    item.func = func_r;
    item.lev  = lev_c;
    item.mt   = MT_W'(mt);
    item.t24  = T24_W'(t) <<< (PQ - X_FRAC_BITS);
  end

  assign push = vld;

endmodule

FILE: rtl/mhw_queue.sv
`include "mexican_hat_wavelet_eval_core_defines.svh"

module mhw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mhw_pkg::item_t  push_item,
  output logic            out_valid,
  output mhw_pkg::item_t  out_item,
  output logic            near_full
);
  import mhw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign pop       = count != '0;
  assign near_full = count >= CNT_W'(QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    out_item <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= pop;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MHW_ASSERT_NOW(a_no_overflow, clk, rst, (push && !pop), (count < CNT_W'(QUEUE_DEPTH)), "queue overflow")
  `MHW_ASSERT_NEXT(a_count_steady, clk, rst, (push && pop), (count == $past(count)), "queue count drift")

endmodule

FILE: rtl/mhw_exp.sv
module mhw_exp (
  input  logic                      clk,
  input  logic [mhw_pkg::Y_W-1:0]   y,
  output logic [mhw_pkg::E_W-1:0]   e24
);
  import mhw_pkg::*;

  localparam int M_W = Y_W;
  localparam logic [EP_W-1:0] ONE = EP_W'(1) << EQ;

  logic [Y_W-1:0]   ya [TAYLOR_TERMS];
  logic [Y_W-1:0]   yb [TAYLOR_TERMS];
  logic [Y_W-1:0]   yc [TAYLOR_TERMS-1];
  logic [M_W-1:0]   ma [TAYLOR_TERMS];
  logic [M_W-1:0]   mb [TAYLOR_TERMS];
  logic [M_W-1:0]   qb [TAYLOR_TERMS];
  logic [EP_W-1:0]  pc [TAYLOR_TERMS];
  logic [EP_W-1:0]  sqr [SQUARINGS];

  for (genvar gi = 0; gi < TAYLOR_TERMS; gi++) begin : g_term
    localparam int unsigned K = TAYLOR_TERMS - gi;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

    logic [Y_W-1:0]   y_in;
    logic [EP_W-1:0]  p_in;
    logic [32:0]      rem;

    if (gi == 0) begin : g_first
      assign y_in = y;
      assign p_in = ONE;
    end else begin : g_next
      assign y_in = yc[gi-1];
      assign p_in = pc[gi-1];
    end

    // floor(m / K) by reciprocal, one correction step
    assign rem = 33'(mb[gi]) - 33'(qb[gi]) * 33'(K);

    always_ff @(posedge clk) begin
      ma[gi] <= M_W'((60'(y_in) * 60'(p_in)) >> EQ);
      ya[gi] <= y_in;
      qb[gi] <= M_W'((62'(ma[gi]) * 62'(RECIP)) >> 32);
      mb[gi] <= ma[gi];
      yb[gi] <= ya[gi];
      pc[gi] <= ONE - EP_W'(qb[gi]) - EP_W'(rem >= 33'(K));
    end

    if (gi < TAYLOR_TERMS - 1) begin : g_ycarry
      always_ff @(posedge clk) begin
        yc[gi] <= yb[gi];
      end
    end
  end

  for (genvar sj = 0; sj < SQUARINGS; sj++) begin : g_sq
    logic [EP_W-1:0] s_in;
    if (sj == 0) begin : g_first
      assign s_in = pc[TAYLOR_TERMS-1];
    end else begin : g_next
      assign s_in = sqr[sj-1];
    end
    always_ff @(posedge clk) begin
      sqr[sj] <= EP_W'((62'(s_in) * 62'(s_in)) >> EQ);
    end
  end

  assign e24 = E_W'(sqr[SQUARINGS-1] >> (EQ - PQ));

endmodule

FILE: rtl/mhw_back.sv
module mhw_back #(
  parameter int X_FRAC_BITS   = mhw_pkg::X_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = mhw_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  mhw_pkg::item_t                    in_item,
  output logic                              done,
  output logic signed [mhw_pkg::VAL_W-1:0]  value,
  output logic                              saturated
);
  import mhw_pkg::*;

  localparam int SQ_W = 2 * MT_W;
  localparam int F2   = 2 * X_FRAC_BITS;
  localparam int SR24 = (F2 >= PQ) ? F2 - PQ : 0;
  localparam int SL24 = (F2 >= PQ) ? 0 : PQ - F2;
  localparam int SR30 = (F2 >= EQ) ? F2 - EQ : 0;
  localparam int SL30 = (F2 >= EQ) ? 0 : EQ - F2;
  localparam int PV_W = 39;
  localparam int PM_W = 38;
  localparam int G_W  = 39;
  localparam int WW   = G_W + 36;
  localparam int DLY  = EXP_LAT - 1;
  localparam logic [VAL_W-1:0] POS_LIM = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_LIM = {1'b1, {(VAL_W-1){1'b0}}};

  // stage 1: square
  logic                     v1;
  logic [SQ_W-1:0]          sq_r;
  logic signed [T24_W-1:0]  t24_1;
  logic [FUNC_W-1:0]        func1;
  logic [LEV_W-1:0]         lev1;
  logic                     zero1;

  // stage 2: polynomial products, exp argument
  logic [S24_W-1:0]         s24;
  logic [Y_W-1:0]           y_c;
  logic signed [31:0]       a1;
  logic [26:0]              magt;
  logic [30:0]              maga;
  logic                     v2;
  logic [S24_W-1:0]         s24_r;
  logic [57:0]              prod1_r;
  logic                     neg1_r;
  logic [59:0]              prod2_r;
  logic [FUNC_W-1:0]        func2;
  logic [LEV_W-1:0]         lev2;
  logic                     zero2;
  logic [Y_W-1:0]           y_r;

  // stage 3: polynomial
  logic signed [PV_W-1:0]   s24_s;
  logic signed [PV_W-1:0]   q1s;
  logic signed [PV_W-1:0]   q2s;
  logic signed [PV_W-1:0]   pv;
  logic                     v3;
  logic signed [PV_W-1:0]   p_r;
  logic [FUNC_W-1:0]        func3;
  logic [LEV_W-1:0]         lev3;
  logic                     zero3;

  // alignment with the exponential
  logic signed [PV_W-1:0]   dp [DLY];
  logic [FUNC_W-1:0]        dfunc [DLY];
  logic [LEV_W-1:0]         dlev [DLY];
  logic                     dzero [DLY];
  logic                     dv [DLY];
  logic [E_W-1:0]           e24;

  // P * E
  logic [PM_W-1:0]          pmag;
  logic                     vg1;
  logic [44:0]              pplo;
  logic [42:0]              pphi;
  logic                     ng1;
  logic [FUNC_W-1:0]        fg1;
  logic [LEV_W-1:0]         lg1;
  logic                     zg1;
  logic                     vg2;
  logic [G_W-1:0]           gmag;
  logic                     ng2;
  logic [FUNC_W-1:0]        fg2;
  logic [LEV_W-1:0]         lg2;
  logic                     zg2;

  // g * C
  logic                     vh1;
  logic [43:0]              hlo;
  logic [42:0]              hhi;
  logic                     nh1;
  logic [FUNC_W-1:0]        fh1;
  logic [LEV_W-1:0]         lh1;
  logic                     zh1;
  logic                     vh2;
  logic [G_W-1:0]           hmag;
  logic                     nh2;
  logic [FUNC_W-1:0]        fh2;
  logic [LEV_W-1:0]         lh2;
  logic                     zh2;

  // scale and saturate
  logic signed [7:0]        l;
  logic [WW-1:0]            wide_c;
  logic                     vs1;
  logic [WW-1:0]            wide;
  logic                     ns1;
  logic                     zs1;
  logic [VAL_W-1:0]         limit;
  logic                     sat_c;
  logic [VAL_W-1:0]         mag_c;

  mhw_exp u_exp (
    .clk (clk),
    .y   (y_r),
    .e24 (e24)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vg1 <= 1'b0;
      vg2 <= 1'b0;
      vh1 <= 1'b0;
      vh2 <= 1'b0;
      vs1 <= 1'b0;
      for (int i = 0; i < DLY; i++) begin
        dv[i] <= 1'b0;
      end
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      dv[0] <= v3;
      for (int i = 1; i < DLY; i++) begin
        dv[i] <= dv[i-1];
      end
      vg1 <= dv[DLY-1];
      vg2 <= vg1;
      vh1 <= vg2;
      vh2 <= vh1;
      vs1 <= vh2;
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= SQ_W'(in_item.mt) * SQ_W'(in_item.mt);
    t24_1 <= in_item.t24;
    func1 <= in_item.func;
    lev1  <= in_item.lev;
    zero1 <= in_item.zero;
  end

  always_comb begin
    s24  = S24_W'((sq_r >> SR24) << SL24);
    y_c  = Y_W'(((sq_r >> SR30) << SL30) >> 7);
    a1   = $signed({2'b00, s24}) - 32'sd50331648;
    magt = 27'(t24_1[T24_W-1] ? -t24_1 : t24_1);
    maga = 31'(a1[31] ? -a1 : a1);
  end

  always_ff @(posedge clk) begin
    s24_r   <= s24;
    prod1_r <= 58'(magt) * 58'(maga);
    neg1_r  <= t24_1[T24_W-1] ^ a1[31];
    prod2_r <= 60'(s24) * 60'(s24);
    func2   <= func1;
    lev2    <= lev1;
    zero2   <= zero1;
    y_r     <= y_c;
  end

  always_comb begin
    s24_s = PV_W'(s24_r);
    q1s   = PV_W'(prod1_r >> PQ);
    q2s   = PV_W'(prod2_r >> PQ);
    case (func2)
      FUNC_VALUE: pv = (PV_W'(1) <<< PQ) - s24_s;
      FUNC_D1:    pv = neg1_r ? -q1s : q1s;
      FUNC_D2:    pv = (s24_s <<< 2) + (s24_s <<< 1) - 39'sd50331648 - q2s;
      default:    pv = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r   <= pv;
    func3 <= func2;
    lev3  <= lev2;
    zero3 <= zero2;
  end

  always_ff @(posedge clk) begin
    dp[0]    <= p_r;
    dfunc[0] <= func3;
    dlev[0]  <= lev3;
    dzero[0] <= zero3;
    for (int i = 1; i < DLY; i++) begin
      dp[i]    <= dp[i-1];
      dfunc[i] <= dfunc[i-1];
      dlev[i]  <= dlev[i-1];
      dzero[i] <= dzero[i-1];
    end
  end

  assign pmag = PM_W'(dp[DLY-1][PV_W-1] ? -dp[DLY-1] : dp[DLY-1]);

  always_ff @(posedge clk) begin
    pplo <= 45'(pmag[19:0]) * 45'(e24);
    pphi <= 43'(pmag[PM_W-1:20]) * 43'(e24);
    ng1  <= dp[DLY-1][PV_W-1];
    fg1  <= dfunc[DLY-1];
    lg1  <= dlev[DLY-1];
    zg1  <= dzero[DLY-1];

    gmag <= G_W'(((64'(pphi) << 20) + 64'(pplo)) >> PQ);
    ng2  <= ng1;
    fg2  <= fg1;
    lg2  <= lg1;
    zg2  <= zg1;

    hlo  <= 44'(gmag[19:0]) * 44'(C_Q24);
    hhi  <= 43'(gmag[G_W-1:20]) * 43'(C_Q24);
    nh1  <= ng2;
    fh1  <= fg2;
    lh1  <= lg2;
    zh1  <= zg2;

    hmag <= G_W'(((64'(hhi) << 20) + 64'(hlo)) >> PQ);
    nh2  <= nh1;
    fh2  <= fh1;
    lh2  <= lh1;
    zh2  <= zh1;
  end

  always_comb begin
    case (fh2)
      FUNC_VALUE: l = 8'(1 + OUT_FRAC_BITS - PQ);
      FUNC_D1:    l = 8'(2 + int'(lh2) + OUT_FRAC_BITS - PQ);
      FUNC_D2:    l = 8'(3 + 2 * int'(lh2) + OUT_FRAC_BITS - PQ);
      default:    l = '0;
    endcase
    if (l[7]) begin
      wide_c = WW'(hmag) >> 7'(-l);
    end else begin
      wide_c = WW'(hmag) << l[6:0];
    end
  end

  always_ff @(posedge clk) begin
    wide <= wide_c;
    ns1  <= nh2;
    zs1  <= zh2;
  end

  always_comb begin
    limit = ns1 ? NEG_LIM : POS_LIM;
    sat_c = wide > WW'(limit);
    mag_c = sat_c ? limit : wide[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      value     <= '0;
      saturated <= 1'b0;
    end else begin
      done <= vs1;
      if (vs1 && !zs1) begin
        value     <= ns1 ? -$signed(mag_c) : $signed(mag_c);
        saturated <= sat_c;
      end else begin
        value     <= '0;
        saturated <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/mexican_hat_wavelet_eval_core.sv
// Dyadic Mexican-hat wavelet evaluator (value, first or second derivative).
// One beat is taken on any cycle with start high and busy low, back to back;
// each result comes out on value/saturated with done high for one cycle, in
// order. The receiver cannot stall. Most of the latency comes from the
// exponential: ten Taylor terms of three pipeline stages each (multiply,
// reciprocal multiply, correction) and six squaring stages. busy only rises
// if the queue between the classify front and the arithmetic pipe nearly
// fills, which a free-running pipe never lets happen.
`include "mexican_hat_wavelet_eval_core_defines.svh"

module mexican_hat_wavelet_eval_core #(
  parameter int X_FRAC_BITS   = mhw_pkg::X_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = mhw_pkg::OUT_FRAC_BITS_DEF,
  parameter int MAX_LEVEL     = mhw_pkg::MAX_LEVEL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [mhw_pkg::FUNC_W-1:0]        func,
  input  logic signed [mhw_pkg::X_W-1:0]    x_pos,
  input  logic [mhw_pkg::LEV_W-1:0]         level,
  input  logic signed [mhw_pkg::K_W-1:0]    shift,
  output logic                              done,
  output logic signed [mhw_pkg::VAL_W-1:0]  value,
  output logic                              saturated
);
  import mhw_pkg::*;

  localparam int LAT = 3 + 2 + EXP_LAT + 6;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic   accept;
  logic   push;
  item_t  push_item;
  logic   q_valid;
  item_t  q_item;

  assign accept = start && !busy;

  mhw_front #(
    .X_FRAC_BITS (X_FRAC_BITS),
    .MAX_LEVEL   (MAX_LEVEL)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .func  (func),
    .x_pos (x_pos),
    .level (level),
    .shift (shift),
    .push  (push),
    .item  (push_item)
  );

  mhw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .out_valid (q_valid),
    .out_item  (q_item),
    .near_full (busy)
  );

  mhw_back #(
    .X_FRAC_BITS   (X_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .done      (done),
    .value     (value),
    .saturated (saturated)
  );

  `MHW_ASSERT_NOW(a_done_latency, clk, rst, done, $past(accept, LAT), "result without matching beat")
  `MHW_ASSERT_NOW(a_sat_with_done, clk, rst, saturated, done, "saturated outside result")
  `MHW_ASSERT_NOW(a_value_with_done, clk, rst, (value != '0), done, "value outside result")
  `MHW_ASSERT_NOW(a_sat_clipped, clk, rst, saturated, ((value == VAL_MAX) || (value == VAL_MIN)), "saturated value not at a limit")

endmodule

FILE: verif/mexican_hat_wavelet_eval_core_tb.sv
`timescale 1ns / 100ps

module mexican_hat_wavelet_eval_core_tb;
  import mhw_pkg::*;

  localparam int MAX_LEV     = MAX_LEVEL_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [FUNC_W-1:0]        func;
  logic signed [X_W-1:0]    x_pos;
  logic [LEV_W-1:0]         level;
  logic signed [K_W-1:0]    shift;
  logic                     done;
  logic signed [VAL_W-1:0]  value;
  logic                     saturated;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } wavelet_result_t;

  wavelet_result_t wavelet_q[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  allow_gaps = 1'b1;

  mexican_hat_wavelet_eval_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .x_pos     (x_pos),
    .level     (level),
    .shift     (shift),
    .done      (done),
    .value     (value),
    .saturated (saturated)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // (a*b) >> sh, truncated toward zero
  function automatic longint mul_trunc(input longint a, input longint b, input int sh);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned pr;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    pr = (ma * mb) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
  endfunction

  function automatic wavelet_result_t wavelet_eval(input logic [FUNC_W-1:0] f,
                                                   input logic signed [X_W-1:0] x,
                                                   input logic [LEV_W-1:0] lv,
                                                   input logic signed [K_W-1:0] k);
    wavelet_result_t r;
    longint u, t, t24, s24, p, g, h, res;
    longint unsigned mt, sq, y, ep, e24, mag, lim;
    longint one24;
    int lev, ms;
    bit neg;
    r.value = '0;
    r.saturated = 1'b0;
    one24 = 64'sd1 <<< PQ;
    lev = (lv > MAX_LEV) ? MAX_LEV : lv;
    if (f == FUNC_NONE) return r;
    u = longint'(x) * (64'sd1 <<< lev) - longint'(k) * 65536;
    t = 2 * u - 65536;
    mt = (t < 0) ? -t : t;
    if (mt >= (64'd8 << 16)) return r;
    sq = mt * mt;
    s24 = longint'(sq >> 8);
    y = (sq >> 2) >> 7;
    ep = 64'd1 << EQ;
    for (int i = TAYLOR_TERMS; i >= 1; i--)
      ep = (64'd1 << EQ) - ((y * ep) >> EQ) / i;
    for (int i = 0; i < SQUARINGS; i++)
      ep = (ep * ep) >> EQ;
    e24 = ep >> (EQ - PQ);
    t24 = t * 256;
    if (f == FUNC_VALUE) begin
      p = one24 - s24;
      ms = 1;
    end else if (f == FUNC_D1) begin
      p = mul_trunc(t24, s24 - 3 * one24, PQ);
      ms = 2 + lev;
    end else begin
      p = -3 * one24 + 6 * s24 - longint'((longint'(s24) * s24) >>> PQ);
      ms = 3 + 2 * lev;
    end
    g = mul_trunc(p, longint'(e24), PQ);
    h = mul_trunc(g, longint'(C_Q24), PQ);
    neg = h < 0;
    mag = neg ? -h : h;
    lim = neg ? (64'd1 << (VAL_W - 1)) : ((64'd1 << (VAL_W - 1)) - 1);
    ms = ms + OUT_FRAC_BITS_DEF - PQ;
    if (mag > (lim >> ms)) begin
      mag = lim;
      r.saturated = 1'b1;
    end else begin
      mag = mag << ms;
    end
    res = neg ? -longint'(mag) : longint'(mag);
    r.value = res[VAL_W-1:0];
    return r;
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic signed [X_W-1:0] x,
                           input logic [LEV_W-1:0] lv, input logic signed [K_W-1:0] k);
    int gap;
    start <= 1'b1;
    func  <= f;
    x_pos <= x;
    level <= lv;
    shift <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    wavelet_q.push_back(wavelet_eval(f, x, lv, k));
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (wavelet_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [FUNC_W-1:0] f;
    for (int i = 0; i < 4; i++) begin
      f = FUNC_W'(i);
      send_beat(f, 18'sd32768, 4'd0, 11'sd0);
    end
    send_beat(FUNC_VALUE, 18'sd131071, 4'd0, 11'sd1);
    send_beat(FUNC_D1, -18'sd131072, 4'd0, -11'sd2);
    send_beat(FUNC_D2, 18'sd0, 4'd0, 11'sd0);
    send_beat(FUNC_D2, 18'sd0, 4'd10, 11'sd0);
    send_beat(FUNC_D1, 18'sd64, 4'd10, 11'sd1);
    send_beat(FUNC_D2, 18'sd100, 4'd15, 11'sd1);
    send_beat(FUNC_D2, 18'sd131071, 4'd10, 11'sd1023);
    send_beat(FUNC_D1, -18'sd131072, 4'd10, -11'sd1024);
    send_beat(FUNC_VALUE, 18'sd0, 4'd0, 11'sd1023);
    send_beat(FUNC_VALUE, 18'sd0, 4'd0, -11'sd1024);
    send_beat(FUNC_VALUE, 18'sd98304, 4'd0, -11'sd4);
    send_beat(FUNC_D2, 18'sd40000, 4'd12, 11'sd24);
    send_beat(FUNC_D1, 18'sd20000, 4'd10, 11'sd305);
    send_beat(FUNC_NONE, -18'sd131072, 4'd15, -11'sd1024);
  endtask

  task automatic test_random(input int count);
    logic [FUNC_W-1:0]       f;
    logic signed [X_W-1:0]   x;
    logic [LEV_W-1:0]        lv;
    logic signed [K_W-1:0]   k;
    longint                  kc;
    int                      le;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      if (n > count * 4 / 5) allow_gaps = 1'b0;
      f = ($urandom_range(0, 19) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
      lv = LEV_W'($urandom_range(0, 15));
      x = X_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        k = K_W'($urandom);
      end else begin
        le = (lv > MAX_LEV) ? MAX_LEV : lv;
        kc = (longint'(x) * (64'sd1 <<< le)) >>> 16;
        kc = kc + $signed($urandom_range(0, 8)) - 4;
        if (kc > 1023) kc = 1023;
        if (kc < -1024) kc = -1024;
        k = kc[K_W-1:0];
      end
      send_beat(f, x, lv, k);
    end
  endtask

  always @(posedge clk) begin
    wavelet_result_t exp_r;
    if (!rst && done) begin
      if (wavelet_q.size() == 0) begin
        $error("result with no beat outstanding: value=%0d", value);
        fail_count++;
      end else begin
        exp_r = wavelet_q.pop_front();
        if (value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, value);
          fail_count++;
        end
        if (saturated !== exp_r.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_r.saturated, saturated);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    func  = '0;
    x_pos = '0;
    level = '0;
    shift = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1750);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && wavelet_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mhw_pkg.sv
rtl/mhw_front.sv
rtl/mhw_queue.sv
rtl/mhw_exp.sv
rtl/mhw_back.sv
rtl/mexican_hat_wavelet_eval_core.sv
verif/mexican_hat_wavelet_eval_core_tb.sv
